### rtl/udpv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// udpv_pkg
// Shared types, constants and helpers of the UDP over IPv4 header validator.
// ----------------------------------------------------------------------------
package udpv_pkg;

  // Width of the per-frame byte counter; the counter saturates at its maximum.
  localparam int CountBits = 16;
  localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};

  // Link header kinds as written to the configuration register
  localparam logic [1:0] LinkLoopback = 2'd0;
  localparam logic [1:0] LinkEthernet = 2'd1;
  localparam logic [1:0] LinkSlip     = 2'd2;
  localparam logic [1:0] LinkPpp      = 2'd3;
  localparam logic [1:0] LinkReset    = LinkEthernet;

  localparam logic [15:0] EthTypeIpv4  = 16'h0800;
  localparam logic [3:0]  IpVersion4   = 4'd4;
  localparam logic [3:0]  IhlMin       = 4'd5;
  localparam logic [7:0]  ProtoUdp     = 8'd17;
  localparam logic [5:0]  MinIpAndUdp  = 6'd28;
  localparam logic [5:0]  UdpHdrBytes  = 6'd8;

  // Byte positions of the Ethernet type word within the frame
  localparam logic [CountBits-1:0] TypeHiPos = CountBits'(12);
  localparam logic [CountBits-1:0] TypeLoPos = CountBits'(13);
  // Offset of the protocol byte within the IP header
  localparam logic [CountBits-1:0] ProtoIdx  = CountBits'(9);

  typedef enum logic [2:0] {
    StsOk          = 3'd0,
    StsTooShort    = 3'd1,
    StsNotIpv4     = 3'd2,
    StsBadVersion  = 3'd3,
    StsBadIhl      = 3'd4,
    StsShortForHdr = 3'd5,
    StsChecksum    = 3'd6,
    StsNotUdp      = 3'd7
  } status_e;

  // Frame summary handed from the front part to the back part on a last byte
  typedef struct packed {
    logic [CountBits-1:0] pos;        // index of the last byte in the frame
    logic [1:0]           link_type;
    logic [15:0]          type_word;
    logic [3:0]           version;
    logic [3:0]           ihl;
    logic [7:0]           protocol;
    logic [15:0]          sum;
  } frame_sum_t;

  // Link header size in bytes
  function automatic logic [4:0] link_size(input logic [1:0] lt);
    logic [4:0] sz;
    case (lt)
      LinkLoopback: sz = 5'd4;
      LinkEthernet: sz = 5'd14;
      LinkSlip:     sz = 5'd24;
      LinkPpp:      sz = 5'd24;
      default:      sz = 5'd24;
    endcase
    return sz;
  endfunction

endpackage
`default_nettype wire

### rtl/udpv_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// udpv_front
// Byte-rate front end: tracks frame position, captures header fields and
// keeps the running ones' complement sum; emits a frame summary on last.
// ----------------------------------------------------------------------------
module udpv_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  input  wire logic [1:0]          cfg_link_type_i,
  input  wire logic                accept_i,
  input  wire logic [7:0]          data_byte_i,
  input  wire logic                last_i,
  output udpv_pkg::frame_sum_t     summary_o
);

  logic [1:0]                     link_type_q;
  logic [udpv_pkg::CountBits-1:0] count_q, count_d;
  logic [15:0]                    type_q, type_d;
  logic [3:0]                     ver_q, ver_d;
  logic [3:0]                     ihl_q, ihl_d;
  logic [7:0]                     prot_q, prot_d;
  logic [15:0]                    sum_q, sum_d;
  logic [7:0]                     hold_q, hold_d;

  logic [udpv_pkg::CountBits-1:0] lsz;
  logic [udpv_pkg::CountBits-1:0] ip_idx;
  logic                           ip_act;
  logic                           in_hdr;
  logic [16:0]                    add_w;

  assign lsz    = udpv_pkg::CountBits'(udpv_pkg::link_size(link_type_q));
  assign ip_act = (count_q >= lsz);
  assign ip_idx = count_q - lsz;

  always_comb begin
    type_d  = type_q;
    ver_d   = ver_q;
    ihl_d   = ihl_q;
    prot_d  = prot_q;
    sum_d   = sum_q;
    hold_d  = hold_q;
    add_w   = {1'b0, sum_q} + {1'b0, hold_q, data_byte_i};
    count_d = (count_q == udpv_pkg::CountMax) ? count_q
                                              : count_q + udpv_pkg::CountBits'(1);

    if (count_q == udpv_pkg::TypeHiPos) begin
      type_d[15:8] = data_byte_i;
    end else if (count_q == udpv_pkg::TypeLoPos) begin
      type_d[7:0] = data_byte_i;
    end

    if (ip_act && (ip_idx == '0)) begin
      ver_d = data_byte_i[7:4];
      ihl_d = data_byte_i[3:0];
    end else if (ip_act && (ip_idx == udpv_pkg::ProtoIdx)) begin
      prot_d = data_byte_i;
    end

    // Sum only the bytes inside the IP header, using the freshly seen IHL
    in_hdr = ip_act && (ip_idx < udpv_pkg::CountBits'({ihl_d, 2'b00}));
    if (in_hdr) begin
      if (!ip_idx[0]) begin
        hold_d = data_byte_i;
      end else begin
        sum_d = add_w[15:0] + 16'(add_w[16]);
      end
    end
  end

  always_comb begin
    summary_o.pos       = count_q;
    summary_o.link_type = link_type_q;
    summary_o.type_word = type_d;
    summary_o.version   = ver_d;
    summary_o.ihl       = ihl_d;
    summary_o.protocol  = prot_d;
    summary_o.sum       = sum_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_type_q <= udpv_pkg::LinkReset;
      count_q     <= '0;
      type_q      <= '0;
      ver_q       <= '0;
      ihl_q       <= '0;
      prot_q      <= '0;
      sum_q       <= '0;
      hold_q      <= '0;
    end else begin
      if (cfg_valid_i) begin
        link_type_q <= cfg_link_type_i;
      end
      if (accept_i) begin
        if (last_i) begin
          count_q <= '0;
          type_q  <= '0;
          ver_q   <= '0;
          ihl_q   <= '0;
          prot_q  <= '0;
          sum_q   <= '0;
          hold_q  <= '0;
        end else begin
          count_q <= count_d;
          type_q  <= type_d;
          ver_q   <= ver_d;
          ihl_q   <= ihl_d;
          prot_q  <= prot_d;
          sum_q   <= sum_d;
          hold_q  <= hold_d;
        end
      end
    end
  end

endmodule
`default_nettype wire

### rtl/udpv_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// udpv_queue
// Two-entry queue of frame summaries between front and back.
// ----------------------------------------------------------------------------
module udpv_queue (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire udpv_pkg::frame_sum_t push_data_i,
  input  wire logic                 pop_i,
  output udpv_pkg::frame_sum_t      pop_data_o,
  output logic                      full_o,
  output logic                      empty_o
);

  udpv_pkg::frame_sum_t entry_q [2];
  logic                 wr_ptr_q, rd_ptr_q;
  logic [1:0]           fill_q;

  assign full_o     = (fill_q == 2'd2);
  assign empty_o    = (fill_q == 2'd0);
  assign pop_data_o = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + 2'd1;
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/udpv_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// udpv_back
// Runs the ordered checks on a frame summary and holds the result item.
// ----------------------------------------------------------------------------
module udpv_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 avail_i,
  input  wire udpv_pkg::frame_sum_t summary_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [2:0]                status_o,
  output logic [5:0]                header_length_o,
  output logic [15:0]               checksum_value_o,
  output logic [6:0]                udp_offset_o
);

  localparam int LenBits = udpv_pkg::CountBits + 1;

  logic               valid_q;
  udpv_pkg::status_e  status_q, status_d;
  logic [5:0]         hlen_q, hlen_d;
  logic [15:0]        cks_q, cks_d;
  logic [6:0]         offs_q, offs_d;

  logic [4:0]         lsz;
  logic [15:0]        cks;
  logic [LenBits-1:0] frame_len;
  logic [6:0]         need_hdr;

  assign pop_o = avail_i && (!valid_q || out_ready_i);

  assign lsz       = udpv_pkg::link_size(summary_i.link_type);
  assign hlen_d    = {summary_i.ihl, 2'b00};
  assign cks       = ~summary_i.sum;
  assign frame_len = {1'b0, summary_i.pos} + LenBits'(1);
  assign need_hdr  = 7'(lsz) + 7'(hlen_d) + 7'(udpv_pkg::UdpHdrBytes);
  assign offs_d    = 7'(lsz) + 7'(hlen_d);

  always_comb begin
    status_d = udpv_pkg::StsOk;
    cks_d    = '0;
    if (frame_len < LenBits'(lsz)) begin
      status_d = udpv_pkg::StsTooShort;
    end else if ((summary_i.link_type == udpv_pkg::LinkEthernet) &&
                 (summary_i.type_word != udpv_pkg::EthTypeIpv4)) begin
      status_d = udpv_pkg::StsNotIpv4;
    end else if (frame_len < LenBits'(7'(lsz) + 7'(udpv_pkg::MinIpAndUdp))) begin
      status_d = udpv_pkg::StsTooShort;
    end else if (summary_i.version != udpv_pkg::IpVersion4) begin
      status_d = udpv_pkg::StsBadVersion;
    end else if (summary_i.ihl < udpv_pkg::IhlMin) begin
      status_d = udpv_pkg::StsBadIhl;
    end else if (frame_len < LenBits'(need_hdr)) begin
      status_d = udpv_pkg::StsShortForHdr;
    end else begin
      cks_d = cks;
      if (cks != 16'h0000) begin
        status_d = udpv_pkg::StsChecksum;
      end else if (summary_i.protocol != udpv_pkg::ProtoUdp) begin
        status_d = udpv_pkg::StsNotUdp;
      end else begin
        status_d = udpv_pkg::StsOk;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      status_q <= status_d;
      hlen_q   <= hlen_d;
      cks_q    <= cks_d;
      offs_q   <= offs_d;
    end
  end

  assign out_valid_o      = valid_q;
  assign status_o         = status_q;
  assign header_length_o  = hlen_q;
  assign checksum_value_o = cks_q;
  assign udp_offset_o     = offs_q;

endmodule
`default_nettype wire

### rtl/udp_ipv4_header_validator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// udp_ipv4_header_validator
// Checks the link, IPv4 and UDP framing of a captured frame, byte by byte.
// ----------------------------------------------------------------------------
// The block takes one frame byte per cycle while in_ready_o is high, link
// header first, and on the byte flagged last it produces one item with a
// status code, the IP header length, the checksum value and the UDP offset.
// It sustains one byte per clock with no gaps between frames unless the
// queue is full: the front part does all per-byte work, including the
// 16-bit end-around-carry add, combinationally. The result item of a frame
// is registered into the queue and then into the output register, which it
// enters when the output is free. Up to three finished frames can wait,
// two in the queue and one in the output register, while the consumer
// stalls; only when the queue is full does in_ready_o drop.
// Write the link type only while no frame is in flight.
// ----------------------------------------------------------------------------
module udp_ipv4_header_validator (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_link_type_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       status_o,
  output logic [5:0]       header_length_o,
  output logic [15:0]      checksum_value_o,
  output logic [6:0]       udp_offset_o
);

  udpv_pkg::frame_sum_t front_sum, queue_sum;
  logic                 accept;
  logic                 q_full, q_empty, q_pop;

  // Configuration is always taken at once
  assign cfg_ready_o = 1'b1;

  // Hold input while the queue has no room for another summary
  assign in_ready_o = !q_full;
  assign accept     = in_valid_i && in_ready_o;

  udpv_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_link_type_i (cfg_link_type_i),
    .accept_i        (accept),
    .data_byte_i     (data_byte_i),
    .last_i          (last_i),
    .summary_o       (front_sum)
  );

  // Push a summary only on the last byte of a frame
  udpv_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept && last_i),
    .push_data_i (front_sum),
    .pop_i       (q_pop),
    .pop_data_o  (queue_sum),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  udpv_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .avail_i          (!q_empty),
    .summary_i        (queue_sum),
    .pop_o            (q_pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .header_length_o  (header_length_o),
    .checksum_value_o (checksum_value_o),
    .udp_offset_o     (udp_offset_o)
  );

endmodule
`default_nettype wire

### rtl/udpv_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// udpv_checker
// Port-level checks of the header validator, bound to the top level.
// ----------------------------------------------------------------------------
module udpv_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [2:0]  status_o,
  input wire logic [5:0]  header_length_o,
  input wire logic [15:0] checksum_value_o,
  input wire logic [6:0]  udp_offset_o
);

  // A stalled result item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
    $stable(header_length_o) && $stable(checksum_value_o) && $stable(udp_offset_o))
    else $error("result item changed while stalled");

  // Checksum value is non-zero exactly on a checksum failure
  a_cks_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != udpv_pkg::StsChecksum) |-> checksum_value_o == 16'h0000)
    else $error("checksum value set outside a checksum failure");

  a_cks_bad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == udpv_pkg::StsChecksum) |-> checksum_value_o != 16'h0000)
    else $error("checksum failure with zero checksum value");

  // A passing frame has a full header and the offset lies past it
  a_ok_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == udpv_pkg::StsOk) |->
    (header_length_o >= 6'd20) && (udp_offset_o >= 7'(header_length_o) + 7'd4))
    else $error("passing frame with short header or offset");

endmodule

bind udp_ipv4_header_validator udpv_checker u_udpv_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .status_o         (status_o),
  .header_length_o  (header_length_o),
  .checksum_value_o (checksum_value_o),
  .udp_offset_o     (udp_offset_o)
);
`default_nettype wire
